// ===== sv/bpe_pkg.sv =====
// Shared constants and state types of the bivariate polynomial evaluator.
package bpe_pkg;

  localparam int unsigned LIMB_W   = 32;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned DEG_W    = 3;
  localparam int unsigned VAL_W    = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    MODE_X,
    MODE_Y,
    MODE_RND
  } mode_e;

endpackage

// ===== sv/bivariate_poly_eval.sv =====
// Bivariate tensor-product polynomial evaluator on a coefficient store.
//
// A request with tuser 0 writes one coefficient into the store; an index
// beyond the store is dropped and no result is sent. A request with tuser 1 evaluates
// P(x,y) = sum coef[i*(d+1)+m] * x^m * y^i for the degree d held in the configuration register
// (0 acts as 1, values above MAX_DEGREE act as MAX_DEGREE) and sends one Q32.32 result, rounded
// half up and saturated, with tuser set on saturation. All coefficients it uses must have been
// written before. The sum is exact: nested Horner steps run on a wide accumulator of L 32-bit
// limbs, L = (COEF_WIDTH + 2*MAX_DEGREE*COORD_WIDTH + 8)/32 + 1 (11 by default), through one
// shared 32 x COORD_WIDTH multiply-add that walks the accumulator one limb per cycle. In an
// evaluation, each coefficient costs a store read, a load and one limb pass, each row one more
// pass along y, and the final rounding one pass. The next request is taken while the previous
// result still waits on the output register.
module bivariate_poly_eval #(
  parameter int unsigned MAX_DEGREE  = 4,
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COEF_WIDTH  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [bpe_pkg::DEG_W-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // coef_index, coef_value, x, y (zero padded to whole bytes)
  input  logic [((bpe_pkg::IDX_W+COEF_WIDTH+2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // op
  input  logic                 s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // value
  output logic [bpe_pkg::VAL_W-1:0] m_axis_tdata_o,
  // overflow
  output logic                 m_axis_tuser_o
);

  localparam int unsigned LimbW     = bpe_pkg::LIMB_W;
  localparam int unsigned IdxW      = bpe_pkg::IDX_W;
  localparam int unsigned ValW      = bpe_pkg::VAL_W;
  localparam int unsigned Depth     = (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned DegW      = $clog2(MAX_DEGREE + 1);
  localparam int unsigned ShW       = $clog2(2 * MAX_DEGREE + 1);
  localparam int unsigned Limbs     = (COEF_WIDTH + 2 * MAX_DEGREE * COORD_WIDTH + 8) / LimbW + 1;
  localparam int unsigned AccW      = Limbs * LimbW;
  localparam int unsigned CntW      = $clog2(Limbs);
  localparam int unsigned CoordFrac = COORD_WIDTH / 2;
  localparam int unsigned CoefFrac  = COEF_WIDTH - 16;
  localparam int unsigned ProdW     = LimbW + COORD_WIDTH + 2;
  localparam int unsigned CarryW    = COORD_WIDTH + 2;
  localparam int unsigned CoefLo    = IdxW;
  localparam int unsigned XLo       = IdxW + COEF_WIDTH;
  localparam int unsigned YLo       = IdxW + COEF_WIDTH + COORD_WIDTH;

  bpe_pkg::state_e state_q, state_d;
  bpe_pkg::mode_e  mode_q;

  logic [bpe_pkg::DEG_W-1:0] deg_q;
  logic [DegW-1:0]           d_q, m_q, i_q, d_clamp;
  logic [AddrW-1:0]          addr_q, start_addr;
  logic [CntW-1:0]           limb_cnt_q;
  logic                      limb_last;
  logic                      out_valid_q, out_free, out_load;
  logic                      in_acc, in_eval, mem_we;

  logic [IdxW-1:0]               in_idx;
  logic [COEF_WIDTH-1:0]         in_coef;
  logic signed [COORD_WIDTH-1:0] x_q, y_q, mul_s;

  logic [COEF_WIDTH-1:0] coef_mem [Depth];
  logic [COEF_WIDTH-1:0] rd_q;

  logic [AccW-1:0]   row_q, total_q, add_q;
  logic [AccW-1:0]   coef_ext, coef_shl, rnd_add, res_w;
  logic [ShW-1:0]    shift_n;
  logic [LimbW-1:0]  tgt_limb, add_limb;
  logic signed [CarryW-1:0] carry_q;
  logic signed [ProdW-1:0]  prod;

  logic [ValW-1:0] out_value_q, res_value;
  logic            out_ovf_q, res_fits;

  assign in_idx  = s_axis_tdata_i[IdxW-1:0];
  assign in_coef = s_axis_tdata_i[CoefLo +: COEF_WIDTH];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_eval = in_acc && s_axis_tuser_i;
  assign mem_we  = in_acc && !s_axis_tuser_i && (in_idx < IdxW'(Depth));

  assign limb_last = (limb_cnt_q == CntW'(Limbs - 1));
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    if (deg_q == '0) begin
      d_clamp = DegW'(1);
    end else if (deg_q > bpe_pkg::DEG_W'(MAX_DEGREE)) begin
      d_clamp = DegW'(MAX_DEGREE);
    end else begin
      d_clamp = DegW'(deg_q);
    end
  end

  always_comb begin
    start_addr = '0;
    for (int j = 1; j <= int'(MAX_DEGREE); j++) begin
      if (d_clamp == DegW'(j)) start_addr = AddrW'((j + 1) * (j + 1) - 1);
    end
  end

  assign shift_n = ShW'({2'b00, d_q, 1'b0} - {2'b00, 1'b0, m_q} - {2'b00, 1'b0, i_q});
  assign coef_ext = {{(AccW - COEF_WIDTH){rd_q[COEF_WIDTH-1]}}, rd_q};

  always_comb begin
    coef_shl = '0;
    for (int j = 0; j <= int'(2 * MAX_DEGREE); j++) begin
      if (shift_n == ShW'(j)) coef_shl = coef_ext << (CoordFrac * j);
    end
  end

  always_comb begin
    int sh;
    rnd_add = '0;
    res_w   = '0;
    for (int j = 1; j <= int'(MAX_DEGREE); j++) begin
      sh = int'(CoefFrac) + 2 * j * int'(CoordFrac) - 32;
      if (d_q == DegW'(j)) begin
        if (sh > 0) rnd_add = AccW'(1) << (sh - 1);
        res_w = AccW'($signed(total_q) >>> sh);
      end
    end
  end

  assign res_fits  = (&res_w[AccW-1:ValW-1]) || !(|res_w[AccW-1:ValW-1]);
  assign res_value = res_fits ? res_w[ValW-1:0] :
                     (total_q[AccW-1] ? {1'b1, {(ValW - 1){1'b0}}} : {1'b0, {(ValW - 1){1'b1}}});

  always_comb begin
    unique case (mode_q)
      bpe_pkg::MODE_X: begin
        tgt_limb = row_q[LimbW-1:0];
        add_limb = add_q[LimbW-1:0];
        mul_s    = x_q;
      end
      bpe_pkg::MODE_Y: begin
        tgt_limb = total_q[LimbW-1:0];
        add_limb = row_q[LimbW-1:0];
        mul_s    = y_q;
      end
      bpe_pkg::MODE_RND: begin
        tgt_limb = total_q[LimbW-1:0];
        add_limb = add_q[LimbW-1:0];
        mul_s    = COORD_WIDTH'(1);
      end
      default: begin
        tgt_limb = '0;
        add_limb = '0;
        mul_s    = '0;
      end
    endcase
  end

  assign prod = $signed({1'b0, tgt_limb}) * mul_s + carry_q + $signed({1'b0, add_limb});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpe_pkg::ST_IDLE: begin
        if (in_eval) state_d = bpe_pkg::ST_READ;
      end
      bpe_pkg::ST_READ: state_d = bpe_pkg::ST_LOAD;
      bpe_pkg::ST_LOAD: state_d = bpe_pkg::ST_RUN;
      bpe_pkg::ST_RUN: begin
        if (limb_last) begin
          unique case (mode_q)
            bpe_pkg::MODE_X:   state_d = (m_q == '0) ? bpe_pkg::ST_RUN : bpe_pkg::ST_READ;
            bpe_pkg::MODE_Y:   state_d = (i_q == '0) ? bpe_pkg::ST_RUN : bpe_pkg::ST_READ;
            bpe_pkg::MODE_RND: state_d = bpe_pkg::ST_FINISH;
            default:           state_d = bpe_pkg::ST_IDLE;
          endcase
        end
      end
      bpe_pkg::ST_FINISH: begin
        if (out_free) state_d = bpe_pkg::ST_IDLE;
      end
      default: state_d = bpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == bpe_pkg::ST_IDLE);
    out_load        = (state_q == bpe_pkg::ST_FINISH) && out_free;
    m_axis_tvalid_o = out_valid_q;
    m_axis_tdata_o  = out_value_q;
    m_axis_tuser_o  = out_ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpe_pkg::ST_IDLE;
      mode_q      <= bpe_pkg::MODE_X;
      deg_q       <= bpe_pkg::DEG_W'(1);
      d_q         <= DegW'(1);
      m_q         <= '0;
      i_q         <= '0;
      addr_q      <= '0;
      limb_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) deg_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        bpe_pkg::ST_IDLE: begin
          if (in_eval) begin
            d_q    <= d_clamp;
            m_q    <= d_clamp;
            i_q    <= d_clamp;
            addr_q <= start_addr;
            mode_q <= bpe_pkg::MODE_X;
          end
        end
        bpe_pkg::ST_LOAD: begin
          addr_q     <= addr_q - 1'b1;
          limb_cnt_q <= '0;
          mode_q     <= bpe_pkg::MODE_X;
        end
        bpe_pkg::ST_RUN: begin
          if (limb_last) begin
            limb_cnt_q <= '0;
            unique case (mode_q)
              bpe_pkg::MODE_X: begin
                if (m_q == '0) begin
                  mode_q <= bpe_pkg::MODE_Y;
                end else begin
                  m_q <= m_q - 1'b1;
                end
              end
              bpe_pkg::MODE_Y: begin
                if (i_q == '0) begin
                  mode_q <= bpe_pkg::MODE_RND;
                end else begin
                  i_q    <= i_q - 1'b1;
                  m_q    <= d_q;
                  mode_q <= bpe_pkg::MODE_X;
                end
              end
              default: ;
            endcase
          end else begin
            limb_cnt_q <= limb_cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) coef_mem[in_idx[AddrW-1:0]] <= in_coef;
    rd_q <= coef_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_eval) begin
      x_q     <= s_axis_tdata_i[XLo +: COORD_WIDTH];
      y_q     <= s_axis_tdata_i[YLo +: COORD_WIDTH];
      total_q <= '0;
    end
    if (out_load) begin
      out_value_q <= res_value;
      out_ovf_q   <= !res_fits;
    end
    unique case (state_q)
      bpe_pkg::ST_LOAD: begin
        add_q   <= coef_shl;
        carry_q <= '0;
        if (m_q == d_q) row_q <= '0;
      end
      bpe_pkg::ST_RUN: begin
        carry_q <= limb_last ? '0 : prod[ProdW-1:LimbW];
        unique case (mode_q)
          bpe_pkg::MODE_X: begin
            row_q <= {prod[LimbW-1:0], row_q[AccW-1:LimbW]};
            add_q <= {add_q[LimbW-1:0], add_q[AccW-1:LimbW]};
          end
          bpe_pkg::MODE_Y: begin
            total_q <= {prod[LimbW-1:0], total_q[AccW-1:LimbW]};
            row_q   <= {row_q[LimbW-1:0], row_q[AccW-1:LimbW]};
            if (limb_last) add_q <= rnd_add;
          end
          bpe_pkg::MODE_RND: begin
            total_q <= {prod[LimbW-1:0], total_q[AccW-1:LimbW]};
            add_q   <= {add_q[LimbW-1:0], add_q[AccW-1:LimbW]};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
